[rtl/core/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// sfe_pkg
// Shared types and constants of the seasonal factor extrapolation core.
// ----------------------------------------------------------------------------
package sfe_pkg;

	// signed width of the wide arithmetic path (products, powers, weight)
	localparam int VW   = 48;
	// signed width of the weight numerator weight*(ratio-1.0)
	localparam int NUMW = 40;
	// width of the difference and power counters
	localparam int KW   = 4;

	localparam logic signed [VW-1:0] ONE_Q16 = 48'sd65536;
	localparam logic signed [VW-1:0] CAP_POW = 48'sd8796093022208;   // 2^43
	localparam logic signed [VW-1:0] CAP_MUL = 48'sd70368744177664;  // 2^46

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_RUN   = 2'd2;

	localparam logic [2:0] CFG_SPAN_BEGIN = 3'd0;
	localparam logic [2:0] CFG_SPAN_END   = 3'd1;
	localparam logic [2:0] CFG_EXTEND_END = 3'd2;
	localparam logic [2:0] CFG_PERIOD     = 3'd3;
	localparam logic [2:0] CFG_DIFF_ORDER = 3'd4;
	localparam logic [2:0] CFG_WEIGHT     = 3'd5;
	localparam logic [2:0] CFG_RATIO      = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_POW, S_POWW, S_WT, S_DIVW, S_COEF, S_COEFW,
		S_PT0, S_PT1, S_TA, S_TB, S_TC, S_TW, S_NEXT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic signed [VW-1:0] a;
		logic signed [VW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                   start;
		logic signed [NUMW-1:0] num;
		logic signed [VW-1:0]   den;
	} div_req_t;

endpackage

[rtl/core/seasonal_factor_extrapolation_core.sv]
// ----------------------------------------------------------------------------
// seasonal_factor_extrapolation_core
// Sample store with forward and backward extrapolation of seasonal factors.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// on read_value/status for exactly one cycle with done high, and cannot be
// held off. Sample writes and reads may be issued back to back: a read
// result shows in the cycle after the item. A run command raises busy
// until it finishes. Its length is set by the serial multiplier and the
// serial divider; setup uses the divider only when the weight needs a
// divide. A run writes L forecast points and, when span_begin exceeds 1,
// L backcast points (L = extend_end - span_end); each point adds ord terms
// (ord = min(diff_order, MAX_ORDER)). A run that would write nothing
// answers without raising busy. The sample store is not cleared at
// reset; read only entries that were written. Configuration writes are
// always taken (cfg_ready is tied high) and must be issued only while the
// core is idle.
// ----------------------------------------------------------------------------
module seasonal_factor_extrapolation_core #(
	parameter int STORE_DEPTH = 1024,
	parameter int MAX_ORDER   = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [10:0]        index,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] read_value,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int VW = sfe_pkg::VW;
	localparam int KW = sfe_pkg::KW;
	localparam int AW = $clog2(STORE_DEPTH);
	// signed position width: room for indexes up to 2047 plus reach
	localparam int PW = ((AW < 11) ? 11 : AW) + 3;
	localparam int KI = $clog2(MAX_ORDER + 1);
	localparam logic signed [PW-1:0] ONE_P   = PW'(1);
	localparam logic signed [PW-1:0] DEPTH_P = PW'(STORE_DEPTH);
	localparam logic [KW-1:0]        MAXO    = KW'(MAX_ORDER);

	// configuration registers
	logic [10:0] span_begin_q, span_end_q, extend_end_q;
	logic [3:0]  period_q;
	logic [2:0]  diff_order_q;
	logic [16:0] weight_q;
	logic [19:0] ratio_q;

	sfe_pkg::state_t state_q, state_d;
	logic done_q, done_d, status_q, status_d, rd_pend_q, rd_pend_d;

	// run datapath
	logic [2:0]             ord_q;
	logic [KW-1:0]          m_q, k_q;
	logic signed [VW-1:0]   p_q, w_q;
	logic signed [VW-1:0]   pw_q   [MAX_ORDER+1];
	logic signed [VW-1:0]   coef_q [MAX_ORDER+1];
	logic signed [PW-1:0]   jpos_q, ka_q, s_q, cnt_q, l_q;
	logic                   back_q;
	logic signed [31:0]     cur_q, x1_q;

	// store port
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, rdata;

	sfe_pkg::mul_req_t      mreq;
	sfe_pkg::div_req_t      dreq;
	logic                   mul_done, div_done;
	logic signed [VW-1:0]   mul_res, div_quot;

	// run checks
	logic signed [PW-1:0] ib_p, ie_p, ke_p, l_p, reach_p;
	logic [2:0]           ord_c;
	logic [KW-1:0]        span_c;
	logic                 run_empty, run_err, idx_ok;

	logic [AW-1:0]        idx_addr, j_addr, ka_addr, kan_addr, jns_addr;
	logic signed [PW-1:0] kan_p, jns_p;
	logic [KW-1:0]        m_inc, pw_k;
	logic signed [VW-1:0] pcap, pw_sel, coef_sel, diff_v;
	logic signed [32:0]   diff33;
	logic signed [VW:0]   acc;
	logic signed [31:0]   sat_v;
	logic signed [20:0]   ratio_m1;
	logic signed [38:0]   num_c;
	logic                 use_div;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != sfe_pkg::S_IDLE);

	// ---- decode and range checks ------------------------------------------
	assign idx_ok   = (index != 11'd0) && ($signed(PW'(index)) <= DEPTH_P);
	assign idx_addr = AW'(index - 11'd1);

	assign ord_c   = ({1'b0, diff_order_q} > MAXO) ? MAXO[2:0] : diff_order_q;
	// years reached back: one with no differences, else order plus one
	assign span_c  = (ord_c == 3'd0) ? KW'(1) : KW'(ord_c) + KW'(1);
	assign ib_p    = $signed(PW'(span_begin_q));
	assign ie_p    = $signed(PW'(span_end_q));
	assign ke_p    = $signed(PW'(extend_end_q));
	assign l_p     = ke_p - ie_p;
	assign reach_p = $signed(PW'(span_c) * PW'(period_q));

	assign run_empty = (l_p <= $signed(PW'(0)));
	assign run_err   = (period_q == 4'd0)
			|| (ie_p + ONE_P - reach_p < ONE_P)
			|| (ke_p > DEPTH_P)
			|| ((ib_p > ONE_P)
				&& ((ib_p - l_p < ONE_P) || (ib_p - ONE_P + reach_p > DEPTH_P)));

	// ---- address arithmetic -------------------------------------------------
	assign jns_p    = jpos_q + s_q;
	assign kan_p    = ka_q + s_q;
	assign j_addr   = AW'(jpos_q - ONE_P);
	assign ka_addr  = AW'(ka_q - ONE_P);
	assign kan_addr = AW'(kan_p - ONE_P);
	assign jns_addr = AW'(jns_p - ONE_P);

	// ---- arithmetic glue ----------------------------------------------------
	assign m_inc    = m_q + KW'(1);
	assign pw_k     = KW'(ord_q) - k_q;
	assign pw_sel   = pw_q[pw_k[KI-1:0]];
	assign coef_sel = coef_q[k_q[KI-1:0]];
	assign pcap     = (mul_res > sfe_pkg::CAP_POW) ? sfe_pkg::CAP_POW : mul_res;

	assign diff33 = $signed({x1_q[31], x1_q}) - $signed({rdata[31], rdata});
	assign diff_v = {{(VW-33){diff33[32]}}, diff33};

	assign acc   = $signed({{(VW-31){cur_q[31]}}, cur_q}) + $signed({mul_res[VW-1], mul_res});
	assign sat_v = (acc > $signed((VW+1)'(32'sh7FFF_FFFF))) ? 32'sh7FFF_FFFF
			: (acc < -$signed((VW+1)'(33'sh0_8000_0000))) ? 32'sh8000_0000
			: acc[31:0];

	assign ratio_m1 = $signed({1'b0, ratio_q}) - 21'sd65536;
	assign num_c    = $signed({1'b0, weight_q}) * ratio_m1;
	assign use_div  = (ratio_q != 20'd65536) && (ord_q != 3'd0) && (p_q != sfe_pkg::ONE_Q16);

	// ---- control ------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		done_d     = 1'b0;
		status_d   = 1'b0;
		rd_pend_d  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = j_addr;
		mem_wdata  = rdata;
		mem_raddr  = ka_addr;
		mreq.start = 1'b0;
		mreq.a     = coef_sel;
		mreq.b     = diff_v;
		dreq.start = 1'b0;
		dreq.num   = {{(sfe_pkg::NUMW-39){num_c[38]}}, num_c};
		dreq.den   = p_q - sfe_pkg::ONE_Q16;
		case (state_q)
			sfe_pkg::S_IDLE: begin
				mem_raddr = idx_addr;
				mem_waddr = idx_addr;
				mem_wdata = value;
				if (start) begin
					case (op)
						sfe_pkg::OP_WRITE: begin
							done_d = 1'b1;
							if (idx_ok) mem_we = 1'b1;
							else status_d = 1'b1;
						end
						sfe_pkg::OP_READ: begin
							if (idx_ok) begin
								rd_pend_d = 1'b1;
							end else begin
								done_d   = 1'b1;
								status_d = 1'b1;
							end
						end
						sfe_pkg::OP_RUN: begin
							if (run_empty) begin
								done_d = 1'b1;
							end else if (run_err) begin
								done_d   = 1'b1;
								status_d = 1'b1;
							end else begin
								state_d = sfe_pkg::S_POW;
							end
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			sfe_pkg::S_POW: begin
				if (m_q == KW'(ord_q)) begin
					state_d = sfe_pkg::S_WT;
				end else begin
					mreq.start = 1'b1;
					mreq.a     = p_q;
					mreq.b     = $signed(VW'(ratio_q));
					state_d    = sfe_pkg::S_POWW;
				end
			end
			sfe_pkg::S_POWW: begin
				if (mul_done) state_d = sfe_pkg::S_POW;
			end
			sfe_pkg::S_WT: begin
				if (use_div) begin
					dreq.start = 1'b1;
					state_d    = sfe_pkg::S_DIVW;
				end else begin
					state_d = sfe_pkg::S_COEF;
				end
			end
			sfe_pkg::S_DIVW: begin
				if (div_done) state_d = sfe_pkg::S_COEF;
			end
			sfe_pkg::S_COEF: begin
				if (k_q > KW'(ord_q)) begin
					state_d = sfe_pkg::S_PT0;
				end else begin
					mreq.start = 1'b1;
					mreq.a     = w_q;
					mreq.b     = pw_sel;
					state_d    = sfe_pkg::S_COEFW;
				end
			end
			sfe_pkg::S_COEFW: begin
				if (mul_done) state_d = sfe_pkg::S_COEF;
			end
			sfe_pkg::S_PT0: begin
				mem_raddr = jns_addr;
				state_d   = sfe_pkg::S_PT1;
			end
			sfe_pkg::S_PT1: begin
				mem_we  = 1'b1;
				state_d = (ord_q == 3'd0) ? sfe_pkg::S_NEXT : sfe_pkg::S_TA;
			end
			sfe_pkg::S_TA: begin
				mem_raddr = ka_addr;
				state_d   = sfe_pkg::S_TB;
			end
			sfe_pkg::S_TB: begin
				mem_raddr = kan_addr;
				state_d   = sfe_pkg::S_TC;
			end
			sfe_pkg::S_TC: begin
				mreq.start = 1'b1;
				state_d    = sfe_pkg::S_TW;
			end
			sfe_pkg::S_TW: begin
				if (mul_done) begin
					mem_we    = 1'b1;
					mem_wdata = sat_v;
					state_d   = (k_q == KW'(ord_q)) ? sfe_pkg::S_NEXT : sfe_pkg::S_TA;
				end
			end
			sfe_pkg::S_NEXT: begin
				if (cnt_q == ONE_P && (back_q || ib_p <= ONE_P)) begin
					done_d  = 1'b1;
					state_d = sfe_pkg::S_IDLE;
				end else begin
					state_d = sfe_pkg::S_PT0;
				end
			end
			default: state_d = sfe_pkg::S_IDLE;
		endcase
	end

	// ---- control and configuration registers -------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sfe_pkg::S_IDLE;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			rd_pend_q    <= 1'b0;
			span_begin_q <= 11'd1;
			span_end_q   <= 11'd1;
			extend_end_q <= 11'd1;
			period_q     <= 4'd12;
			diff_order_q <= 3'd1;
			weight_q     <= 17'd32768;
			ratio_q      <= 20'd65536;
		end else begin
			state_q   <= state_d;
			done_q    <= done_d;
			status_q  <= status_d;
			rd_pend_q <= rd_pend_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sfe_pkg::CFG_SPAN_BEGIN: span_begin_q <= cfg_data[10:0];
					sfe_pkg::CFG_SPAN_END:   span_end_q   <= cfg_data[10:0];
					sfe_pkg::CFG_EXTEND_END: extend_end_q <= cfg_data[10:0];
					sfe_pkg::CFG_PERIOD:     period_q     <= cfg_data[3:0];
					sfe_pkg::CFG_DIFF_ORDER: diff_order_q <= cfg_data[2:0];
					sfe_pkg::CFG_WEIGHT:     weight_q     <= cfg_data[16:0];
					sfe_pkg::CFG_RATIO:      ratio_q      <= cfg_data[19:0];
					default: ;
				endcase
			end
		end
	end

	// ---- run datapath -------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			sfe_pkg::S_IDLE: begin
				// latch the run setup; powers start at 1.0
				if (start && op == sfe_pkg::OP_RUN) begin
					ord_q     <= ord_c;
					p_q       <= sfe_pkg::ONE_Q16;
					m_q       <= '0;
					pw_q[0]   <= sfe_pkg::ONE_Q16;
					l_q       <= l_p;
				end
			end
			sfe_pkg::S_POWW: begin
				if (mul_done) begin
					p_q               <= pcap;
					pw_q[m_inc[KI-1:0]] <= pcap;
					m_q               <= m_inc;
				end
			end
			sfe_pkg::S_WT: begin
				w_q <= $signed(VW'(weight_q));
				k_q <= KW'(1);
			end
			sfe_pkg::S_DIVW: begin
				if (div_done) w_q <= div_quot;
			end
			sfe_pkg::S_COEF: begin
				// coefficients done: set up the forecast pass
				if (k_q > KW'(ord_q)) begin
					jpos_q <= ie_p + ONE_P;
					s_q    <= -$signed(PW'(period_q));
					cnt_q  <= l_q;
					back_q <= 1'b0;
				end
			end
			sfe_pkg::S_COEFW: begin
				if (mul_done) begin
					coef_q[k_q[KI-1:0]] <= mul_res;
					k_q                 <= k_q + KW'(1);
				end
			end
			sfe_pkg::S_PT0: begin
				ka_q <= jns_p;
				k_q  <= KW'(1);
			end
			sfe_pkg::S_PT1: begin
				cur_q <= rdata;
			end
			sfe_pkg::S_TB: begin
				x1_q <= rdata;
			end
			sfe_pkg::S_TW: begin
				if (mul_done) begin
					cur_q <= sat_v;
					ka_q  <= kan_p;
					k_q   <= k_q + KW'(1);
				end
			end
			sfe_pkg::S_NEXT: begin
				if (cnt_q == ONE_P) begin
					// forecast done: mirror into the backcast pass
					if (!back_q && ib_p > ONE_P) begin
						jpos_q <= ib_p - ONE_P;
						s_q    <= $signed(PW'(period_q));
						cnt_q  <= l_q;
						back_q <= 1'b1;
					end
				end else begin
					cnt_q  <= cnt_q - ONE_P;
					jpos_q <= back_q ? (jpos_q - ONE_P) : (jpos_q + ONE_P);
				end
			end
			default: ;
		endcase
	end

	// ---- results ------------------------------------------------------------
	assign done       = done_q | rd_pend_q;
	assign status     = status_q;
	assign read_value = rd_pend_q ? $signed(rdata) : 32'sd0;

	// ---- units --------------------------------------------------------------
	sfe_store #(
		.DEPTH(STORE_DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	sfe_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.done  (mul_done),
		.res   (mul_res)
	);

	sfe_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.done  (div_done),
		.quot  (div_quot)
	);

endmodule

[rtl/core/sfe_store.sv]
// ----------------------------------------------------------------------------
// sfe_store
// Series sample memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfe_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/sfe_mul.sv]
// ----------------------------------------------------------------------------
// sfe_mul
// Serial signed Q16 multiplier, one multiplier bit per cycle, rounded half
// away from zero and saturated at magnitude 2^46.
// ----------------------------------------------------------------------------
module sfe_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sfe_pkg::mul_req_t           req,
	output logic                        done,
	output logic signed [sfe_pkg::VW-1:0] res
);

	localparam int VW  = sfe_pkg::VW;
	localparam int PRW = 2 * VW;
	localparam int CW  = $clog2(VW);

	logic [VW-1:0]  ua_q, ub_q;
	logic [PRW-1:0] prod_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic           run_q, fin_q;

	logic [VW-1:0]  ua_c, ub_c;
	logic [PRW:0]   rnd_sum;
	logic [PRW-16:0] rnd;
	logic [VW-1:0]  mag_r;

	assign ua_c = req.a[VW-1] ? VW'(-req.a) : VW'(req.a);
	assign ub_c = req.b[VW-1] ? VW'(-req.b) : VW'(req.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CW'(VW - 1)) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q   <= ua_c;
			ub_q   <= ub_c;
			neg_q  <= req.a[VW-1] ^ req.b[VW-1];
			prod_q <= '0;
			cnt_q  <= '0;
		end else if (run_q) begin
			// shift in the next multiplier bit, MSB first
			prod_q <= {prod_q[PRW-2:0], 1'b0} + (ub_q[VW-1] ? PRW'(ua_q) : '0);
			ub_q   <= {ub_q[VW-2:0], 1'b0};
			cnt_q  <= cnt_q + 1'b1;
		end
	end

	assign rnd_sum = {1'b0, prod_q} + (PRW+1)'(32768);
	assign rnd     = rnd_sum[PRW:16];
	assign mag_r   = (rnd > (PRW-15)'(sfe_pkg::CAP_MUL)) ? VW'(sfe_pkg::CAP_MUL) : VW'(rnd);
	assign res     = neg_q ? -$signed(mag_r) : $signed(mag_r);
	assign done    = fin_q;

endmodule

[rtl/core/sfe_div.sv]
// ----------------------------------------------------------------------------
// sfe_div
// Serial restoring divider, one quotient bit per cycle, quotient rounded
// half away from zero.
// ----------------------------------------------------------------------------
module sfe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfe_pkg::div_req_t             req,
	output logic                          done,
	output logic signed [sfe_pkg::VW-1:0] quot
);

	localparam int VW   = sfe_pkg::VW;
	localparam int NUMW = sfe_pkg::NUMW;
	localparam int DW   = VW + 1;
	localparam int CW   = $clog2(DW);

	logic [DW-1:0]   nq_q, rem_q;
	logic [VW-1:0]   dv_q;
	logic            neg_q;
	logic [CW-1:0]   cnt_q;
	logic            run_q, fin_q;

	logic [NUMW-1:0] un_c;
	logic [VW-1:0]   ud_c;
	logic [DW-1:0]   trial;
	logic            ge;

	assign un_c  = req.num[NUMW-1] ? NUMW'(-req.num) : NUMW'(req.num);
	assign ud_c  = req.den[VW-1] ? VW'(-req.den) : VW'(req.den);
	assign trial = {rem_q[DW-2:0], nq_q[DW-1]};
	assign ge    = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == CW'(DW - 1)) begin
				run_q <= 1'b0;
				fin_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// add half the divisor up front for rounding
			nq_q  <= DW'(un_c) + DW'(ud_c >> 1);
			dv_q  <= ud_c;
			rem_q <= '0;
			neg_q <= req.num[NUMW-1] ^ req.den[VW-1];
			cnt_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? (trial - {1'b0, dv_q}) : trial;
			nq_q  <= {nq_q[DW-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign quot = neg_q ? -$signed(nq_q[VW-1:0]) : $signed(nq_q[VW-1:0]);
	assign done = fin_q;

endmodule
